[hdl/capsule_point_cloud_collision_macros.svh]
// Assertion macros used by the capsule collision checker.
`ifndef CAPSULE_POINT_CLOUD_COLLISION_MACROS_SVH
`define CAPSULE_POINT_CLOUD_COLLISION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cpc_pkg.sv]
// Shared constants, types and helpers of the capsule collision block.
package cpc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int AXES          = 3;
    localparam int AB_BITS       = COORD_BITS + 1;
    localparam int SQ_BITS       = 2 * AB_BITS;
    localparam int SUM_BITS      = SQ_BITS;
    localparam int DOT_BITS      = SUM_BITS + 1;
    localparam int WIDE_BITS     = SUM_BITS + 6;
    localparam int RADIUS_BITS   = 14;
    localparam int R2_BITS       = 2 * RADIUS_BITS;
    localparam int LIMIT_BITS    = 8;
    localparam int COUNT_BITS    = 8;
    localparam int HALF_BITS     = ((SUM_BITS > R2_BITS ? SUM_BITS : R2_BITS) + 1) / 2;
    localparam int MUL_BITS      = 2 * HALF_BITS;
    localparam int PP_BITS       = 2 * HALF_BITS;
    localparam int PROD_BITS     = 2 * MUL_BITS;
    localparam int RHS_BITS      = PROD_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS > RADIUS_BITS ? COORD_BITS : RADIUS_BITS;

    // Classifier pipeline depth and the queue behind it (depth is a power of two).
    localparam int FRONT_STAGES  = 5;
    localparam int QUEUE_DEPTH   = 8;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    // Wide products formed from 4 half-width partial products.
    localparam int NUM_PROD      = 3;
    localparam int PP_TERMS      = 4;
    localparam int PROD_AP2_LEN  = 0;
    localparam int PROD_DOT_SQ   = 1;
    localparam int PROD_R2_LEN   = 2;
    localparam int PP_LO_LO      = 0;
    localparam int PP_LO_HI      = 1;
    localparam int PP_HI_LO      = 2;
    localparam int PP_HI_HI      = 3;

    // Projection window -0.05..1.05 scaled by 20.
    localparam int T_SCALE       = 20;
    localparam int T_HIGH        = 21;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [AB_BITS-1:0]    ab_t;
    typedef logic signed [SQ_BITS-1:0]    sq_t;
    typedef logic        [SUM_BITS-1:0]   sum_t;
    typedef logic signed [DOT_BITS-1:0]   dot_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic        [RADIUS_BITS-1:0] radius_t;
    typedef logic        [R2_BITS-1:0]    r2_t;
    typedef logic        [LIMIT_BITS-1:0] limit_t;
    typedef logic        [COUNT_BITS-1:0] count_t;
    typedef logic        [MUL_BITS-1:0]   mul_t;
    typedef logic        [PP_BITS-1:0]    pp_t;
    typedef logic        [PROD_BITS-1:0]  prod_t;
    typedef logic        [RHS_BITS-1:0]   rhs_t;

    localparam sum_t    SHORT_LEN       = sum_t'(100);
    localparam radius_t RADIUS_RESET    = radius_t'(800);
    localparam limit_t  HIT_LIMIT_RESET = limit_t'(3);
    localparam count_t  COUNT_MAX       = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SEG_START_X    = 3'd0,
        CFG_SEG_START_Y    = 3'd1,
        CFG_SEG_START_Z    = 3'd2,
        CFG_SEG_END_X      = 3'd3,
        CFG_SEG_END_Y      = 3'd4,
        CFG_SEG_END_Z      = 3'd5,
        CFG_CAPSULE_RADIUS = 3'd6,
        CFG_HIT_LIMIT      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        coord_t [AXES-1:0] seg_start;
        coord_t [AXES-1:0] seg_end;
        radius_t           capsule_radius;
        limit_t            hit_limit;
    } cfg_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } point_t;

    typedef struct packed {
        logic close;
        logic last;
    } q_entry_t;

    typedef struct packed {
        logic valid;
        logic close;
        logic last;
    } q_head_t;

    // Recombine four half-width partial products into the full product.
    function automatic prod_t join_pp(input pp_t lo_lo, input pp_t lo_hi,
                                      input pp_t hi_lo, input pp_t hi_hi);
        prod_t acc;
        acc = (prod_t'(hi_hi) << MUL_BITS)
            + ((prod_t'(lo_hi) + prod_t'(hi_lo)) << HALF_BITS)
            + prod_t'(lo_lo);
        return acc;
    endfunction

endpackage

[hdl/cpc_if.sv]
// Channel interfaces: point stream, result stream and configuration writes.
interface cpc_point_if import cpc_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   last_point;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output last_point, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input last_point, output ready);
endinterface

interface cpc_result_if import cpc_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   collision;
    count_t close_count;

    modport source (output valid, output collision, output close_count, input ready);
    modport sink   (input valid, input collision, input close_count, output ready);
endinterface

interface cpc_cfg_if import cpc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/cpc_cfg.sv]
// Configuration register file of the capsule collision block.
module cpc_cfg import cpc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    cpc_cfg_if.sink cfg,
    output cfg_t    cfg_q
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seg_start      <= '0;
            cfg_reg.seg_end        <= '0;
            cfg_reg.capsule_radius <= RADIUS_RESET;
            cfg_reg.hit_limit      <= HIT_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_SEG_START_X:    cfg_reg.seg_start[0]   <= cfg.data[COORD_BITS-1:0];
                CFG_SEG_START_Y:    cfg_reg.seg_start[1]   <= cfg.data[COORD_BITS-1:0];
                CFG_SEG_START_Z:    cfg_reg.seg_start[2]   <= cfg.data[COORD_BITS-1:0];
                CFG_SEG_END_X:      cfg_reg.seg_end[0]     <= cfg.data[COORD_BITS-1:0];
                CFG_SEG_END_Y:      cfg_reg.seg_end[1]     <= cfg.data[COORD_BITS-1:0];
                CFG_SEG_END_Z:      cfg_reg.seg_end[2]     <= cfg.data[COORD_BITS-1:0];
                CFG_CAPSULE_RADIUS: cfg_reg.capsule_radius <= cfg.data[RADIUS_BITS-1:0];
                CFG_HIT_LIMIT:      cfg_reg.hit_limit      <= cfg.data[LIMIT_BITS-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

endmodule

[hdl/cpc_front.sv]
// Point classifier pipeline: marks each point close to the capsule or not.
module cpc_front import cpc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg_q,
    input  logic     in_fire,
    input  point_t   in_point,
    output logic     push,
    output q_entry_t push_entry
);

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] last_reg;

    // stage 1: offsets from the segment start
    ab_t   ap_reg  [AXES];
    ab_t   ab_reg  [AXES];
    // stage 2: per-axis products
    sq_t   dotp_reg [AXES];
    sq_t   app_reg  [AXES];
    sq_t   abb_reg  [AXES];
    // stage 3: sums
    sum_t  len_reg;
    sum_t  ap2_reg;
    dot_t  d_reg;
    r2_t   r2_reg;
    // stage 4: window flags and partial products
    logic  keep4_reg;
    pp_t   pp_reg [NUM_PROD][PP_TERMS];
    // stage 5: full products
    logic  keep5_reg;
    prod_t lhs_reg;
    prod_t d2_reg;
    prod_t r2l_reg;

    coord_t pt [AXES];
    wide_t  d20;
    wide_t  lenw;
    logic   skip;
    dot_t   dneg;
    mul_t   dmag;
    mul_t   a_op [NUM_PROD];
    mul_t   b_op [NUM_PROD];

    always_comb
    begin
        pt[0] = in_point.x;
        pt[1] = in_point.y;
        pt[2] = in_point.z;

        // Skip points whose projection lies outside -0.05..1.05 of the segment.
        d20  = wide_t'(T_SCALE) * wide_t'(d_reg);
        lenw = wide_t'(len_reg);
        skip = (d20 < -lenw) || (d20 > wide_t'(T_HIGH) * lenw);

        dneg = -d_reg;
        dmag = mul_t'(d_reg[DOT_BITS-1] ? dneg : d_reg);

        a_op[PROD_AP2_LEN] = mul_t'(ap2_reg);
        b_op[PROD_AP2_LEN] = mul_t'(len_reg);
        a_op[PROD_DOT_SQ]  = dmag;
        b_op[PROD_DOT_SQ]  = dmag;
        a_op[PROD_R2_LEN]  = mul_t'(r2_reg);
        b_op[PROD_R2_LEN]  = mul_t'(len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_fire};
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[FRONT_STAGES-2:0], in_point.last};

        for (int i = 0; i < AXES; i++)
        begin
            ap_reg[i]   <= ab_t'($signed(pt[i])) - ab_t'($signed(cfg_q.seg_start[i]));
            ab_reg[i]   <= ab_t'($signed(cfg_q.seg_end[i]))
                         - ab_t'($signed(cfg_q.seg_start[i]));
            dotp_reg[i] <= sq_t'(ap_reg[i]) * sq_t'(ab_reg[i]);
            app_reg[i]  <= sq_t'(ap_reg[i]) * sq_t'(ap_reg[i]);
            abb_reg[i]  <= sq_t'(ab_reg[i]) * sq_t'(ab_reg[i]);
        end

        len_reg <= sum_t'(abb_reg[0]) + sum_t'(abb_reg[1]) + sum_t'(abb_reg[2]);
        ap2_reg <= sum_t'(app_reg[0]) + sum_t'(app_reg[1]) + sum_t'(app_reg[2]);
        d_reg   <= dot_t'(dotp_reg[0]) + dot_t'(dotp_reg[1]) + dot_t'(dotp_reg[2]);
        r2_reg  <= r2_t'(cfg_q.capsule_radius) * r2_t'(cfg_q.capsule_radius);

        // A segment whose squared length is below SHORT_LEN never counts a point.
        keep4_reg <= (len_reg >= SHORT_LEN) && !skip;
        for (int k = 0; k < NUM_PROD; k++)
        begin
            pp_reg[k][PP_LO_LO] <= pp_t'(a_op[k][HALF_BITS-1:0])
                                 * pp_t'(b_op[k][HALF_BITS-1:0]);
            pp_reg[k][PP_LO_HI] <= pp_t'(a_op[k][HALF_BITS-1:0])
                                 * pp_t'(b_op[k][MUL_BITS-1:HALF_BITS]);
            pp_reg[k][PP_HI_LO] <= pp_t'(a_op[k][MUL_BITS-1:HALF_BITS])
                                 * pp_t'(b_op[k][HALF_BITS-1:0]);
            pp_reg[k][PP_HI_HI] <= pp_t'(a_op[k][MUL_BITS-1:HALF_BITS])
                                 * pp_t'(b_op[k][MUL_BITS-1:HALF_BITS]);
        end

        keep5_reg <= keep4_reg;
        lhs_reg   <= join_pp(pp_reg[PROD_AP2_LEN][PP_LO_LO], pp_reg[PROD_AP2_LEN][PP_LO_HI],
                             pp_reg[PROD_AP2_LEN][PP_HI_LO], pp_reg[PROD_AP2_LEN][PP_HI_HI]);
        d2_reg    <= join_pp(pp_reg[PROD_DOT_SQ][PP_LO_LO], pp_reg[PROD_DOT_SQ][PP_LO_HI],
                             pp_reg[PROD_DOT_SQ][PP_HI_LO], pp_reg[PROD_DOT_SQ][PP_HI_HI]);
        r2l_reg   <= join_pp(pp_reg[PROD_R2_LEN][PP_LO_LO], pp_reg[PROD_R2_LEN][PP_LO_HI],
                             pp_reg[PROD_R2_LEN][PP_HI_LO], pp_reg[PROD_R2_LEN][PP_HI_HI]);
    end

    // close when |AP|^2*L - d^2 < r^2*L
    always_comb
    begin
        push             = vld_reg[FRONT_STAGES-1];
        push_entry.last  = last_reg[FRONT_STAGES-1];
        push_entry.close = keep5_reg
                        && (rhs_t'(lhs_reg) < rhs_t'(d2_reg) + rhs_t'(r2l_reg));
    end

endmodule

[hdl/cpc_queue.sv]
// Short queue of classified points between the classifier and the counter.
module cpc_queue import cpc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_head_t  head
);

    q_entry_t             mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic [QCNT_BITS-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg + QCNT_BITS'(push) - QCNT_BITS'(pop);

        head.valid = (cnt_reg != '0);
        head.close = mem[rd_ptr_reg].close;
        head.last  = mem[rd_ptr_reg].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[hdl/cpc_back.sv]
// Close-point counter, collision decision and result register.
module cpc_back import cpc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  q_head_t       head,
    input  limit_t        hit_limit,
    output logic          pop,
    cpc_result_if.source  result
);

    count_t hit_cnt_reg;
    count_t hit_cnt_next;
    logic   decided_reg;
    logic   decided_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   collision_reg;
    logic   collision_next;
    count_t count_reg;
    count_t count_next;

    count_t cnt_inc;
    count_t cnt_after;
    logic   counted;
    logic   emit_hit;
    logic   emit_end;
    logic   take;

    always_comb
    begin
        take = !out_valid_reg || result.ready;
        pop  = head.valid && take;

        // saturate at the top of the counter
        cnt_inc   = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg : hit_cnt_reg + count_t'(1);
        counted   = !decided_reg && head.close;
        cnt_after = counted ? cnt_inc : hit_cnt_reg;
        emit_hit  = counted && (cnt_inc > hit_limit);
        emit_end  = !decided_reg && !emit_hit && head.last;

        hit_cnt_next   = hit_cnt_reg;
        decided_next   = decided_reg;
        out_valid_next = out_valid_reg && !result.ready;
        collision_next = collision_reg;
        count_next     = count_reg;

        if (pop)
        begin
            if (head.last)
            begin
                hit_cnt_next = '0;
                decided_next = 1'b0;
            end
            else
            begin
                hit_cnt_next = cnt_after;
                decided_next = decided_reg || emit_hit;
            end
            if (emit_hit || emit_end)
            begin
                out_valid_next = 1'b1;
                collision_next = emit_hit;
                count_next     = cnt_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            decided_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hit_cnt_reg   <= hit_cnt_next;
            decided_reg   <= decided_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        collision_reg <= collision_next;
        count_reg     <= count_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.collision   = collision_reg;
    assign result.close_count = count_reg;

endmodule

[hdl/capsule_point_cloud_collision.sv]
// Top level of the capsule versus point cloud collision block.
// Throughput: one point per cycle while ready; point.ready follows a credit count
// of QUEUE_DEPTH that spans the five-stage classifier pipeline and the queue.
// Reset: rst_n clears the pipeline, queue, counter and result register and loads
// the register defaults (segment at origin, radius 800, hit limit 3).
module capsule_point_cloud_collision import cpc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    cpc_cfg_if.sink      cfg,
    cpc_point_if.sink    point,
    cpc_result_if.source result
);

    // Credits: points accepted but not yet drained from the queue. Every point
    // in the classifier is guaranteed a queue slot, so the pipeline never stalls.
    logic [QCNT_BITS-1:0] occ_reg;
    logic [QCNT_BITS-1:0] occ_next;

    cfg_t     cfg_q;
    point_t   in_point;
    logic     accept;
    logic     push;
    q_entry_t push_entry;
    logic     pop;
    q_head_t  head;

    always_comb
    begin
        point.ready = (occ_reg < QCNT_BITS'(QUEUE_DEPTH));
        accept      = point.valid && point.ready;

        in_point.x    = point.point_x;
        in_point.y    = point.point_y;
        in_point.z    = point.point_z;
        in_point.last = point.last_point;

        occ_next = occ_reg + QCNT_BITS'(accept) - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Register file; the user must write it only while the block is idle, which the block does not enforce.
    cpc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Front: geometry of each point against the capsule, one accepted point a cycle.
    cpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_q      (cfg_q),
        .in_fire    (accept),
        .in_point   (in_point),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the classifier from the result side so the result side may stall.
    cpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head)
    );

    // Back: count close points, decide, hold the result until taken.
    cpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .hit_limit (cfg_q.hit_limit),
        .pop       (pop),
        .result    (result)
    );

endmodule

[hdl/cpc_checker.sv]
// Port-level checker of the capsule collision block and its bind.
`include "capsule_point_cloud_collision_macros.svh"

module cpc_checker import cpc_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    input logic   pnt_valid,
    input logic   pnt_ready,
    input logic   res_valid,
    input logic   res_ready,
    input logic   collision,
    input count_t close_count
);

    `CPC_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(collision) && $stable(close_count), "result transaction changed while stalled")
    `CPC_ASSERT_NOW(a_idle_after_reset, !$past(rst_n), !res_valid && pnt_ready, "block not idle after reset")
    `CPC_ASSERT_NOW(a_ready_falls_on_accept, $fell(pnt_ready), $past(pnt_valid && pnt_ready), "point ready fell without an accepted transaction")
    `CPC_ASSERT_NOW(a_collision_has_count, res_valid && collision, close_count != '0, "collision reported with zero close count")

endmodule

bind capsule_point_cloud_collision cpc_checker u_cpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pnt_valid   (point.valid),
    .pnt_ready   (point.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .collision   (result.collision),
    .close_count (result.close_count)
);
